[rtl/core/oplook_pkg.sv]
`timescale 1ns / 1ps

package oplook_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] map_id;
        logic [31:0] user_id;
        logic [31:0] ip_addr;
        logic [5:0]  prefix_len;
        logic [31:0] location;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic write;
        logic rd_en;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
        logic scan_more;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic       ok;
        logic [4:0] rank;
    } t_rank;

    // position of a prefix length in the probe sequence, lower is tried first
    function automatic t_rank prefix_rank(input logic [5:0] len);
        t_rank r;
        r.ok = 1'b1;
        unique case (len)
            6'd24:   r.rank = 5'd0;
            6'd28:   r.rank = 5'd1;
            6'd29:   r.rank = 5'd2;
            6'd27:   r.rank = 5'd3;
            6'd32:   r.rank = 5'd4;
            6'd23:   r.rank = 5'd5;
            6'd26:   r.rank = 5'd6;
            6'd30:   r.rank = 5'd7;
            6'd25:   r.rank = 5'd8;
            6'd22:   r.rank = 5'd9;
            6'd19:   r.rank = 5'd10;
            6'd21:   r.rank = 5'd11;
            6'd20:   r.rank = 5'd12;
            6'd16:   r.rank = 5'd13;
            6'd18:   r.rank = 5'd14;
            6'd31:   r.rank = 5'd15;
            6'd17:   r.rank = 5'd16;
            default: begin
                // short prefixes 15 down to 1 follow in order
                if (len >= 6'd1 && len <= 6'd15) begin
                    r.rank = 5'(6'd32 - len);
                end else begin
                    r.ok   = 1'b0;
                    r.rank = 5'd0;
                end
            end
        endcase
        return r;
    endfunction

    // top len bits set; len of 32 gives all ones
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        return ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

[rtl/core/oplook_ram.sv]
`timescale 1ns / 1ps

module oplook_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/oplook_ctrl.sv]
`timescale 1ns / 1ps

module oplook_ctrl
    import oplook_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_START;
            S_START: n_state = i_sts.is_lookup ? S_SCAN : S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_SCAN:  if (!i_sts.scan_more) n_state = S_DRAIN;
            S_DRAIN: if (!i_sts.pipe_busy) n_state = S_OUT;
            S_OUT:   if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_WRITE: o_cmd.write    = 1'b1;
            S_SCAN:  o_cmd.rd_en    = i_sts.scan_more;
            S_OUT:   o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

[rtl/core/oplook_dp.sv]
`timescale 1ns / 1ps

module oplook_dp
    import oplook_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd_ctl,
    output t_dp_sts     o_sts,
    input  logic        i_cmd,
    input  logic [31:0] i_map_id,
    input  logic [31:0] i_user_id,
    input  logic [31:0] i_ip_addr,
    input  logic [5:0]  i_prefix_len,
    input  logic [31:0] i_location,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_location
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(t_entry);

    logic          r_cmd;
    t_entry        r_item;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [1:0]    r_ins_status;

    logic          r_v1;
    logic          r_v2;
    logic          r_hit;
    logic [4:0]    r_rank;
    logic [31:0]   r_val;

    logic          r_best_found;
    logic [4:0]    r_best_rank;
    logic [31:0]   r_best_loc;

    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [31:0]   r_found_location;

    logic          full;
    logic          we;
    logic [EW-1:0] rdata;
    t_entry        rd_entry;
    t_rank         rd_rank;
    logic          rd_hit;

    assign full = (r_count == CW'(TABLE_ENTRIES));
    assign we   = i_cmd_ctl.write && !full;

    oplook_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_item),
        .i_re    (i_cmd_ctl.rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    // entry matches when ids agree, length is probed and address equals the masked key
    assign rd_entry = t_entry'(rdata);
    assign rd_rank  = prefix_rank(rd_entry.prefix_len);
    assign rd_hit   = rd_rank.ok
                   && rd_entry.map_id  == r_item.map_id
                   && rd_entry.user_id == r_item.user_id
                   && rd_entry.ip_addr == (r_item.ip_addr & prefix_mask(rd_entry.prefix_len));

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.capture) begin
            r_cmd             <= i_cmd;
            r_item.map_id     <= i_map_id;
            r_item.user_id    <= i_user_id;
            r_item.ip_addr    <= i_ip_addr;
            r_item.prefix_len <= i_prefix_len;
            r_item.location   <= i_location;
        end
        if (i_cmd_ctl.write) begin
            r_ins_status <= full ? ST_FULL : ST_OK;
        end
        r_hit  <= rd_hit;
        r_rank <= rd_rank.rank;
        r_val  <= rd_entry.location;
        if (r_v2 && r_hit && (!r_best_found || r_rank < r_best_rank)) begin
            r_best_rank <= r_rank;
            r_best_loc  <= r_val;
        end
        if (i_cmd_ctl.load_out) begin
            if (r_cmd == CMD_INSERT) begin
                r_status         <= r_ins_status;
                r_found_location <= '0;
            end else if (r_best_found) begin
                r_status         <= ST_OK;
                r_found_location <= r_best_loc;
            end else begin
                r_status         <= ST_NOT_FOUND;
                r_found_location <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_v1 <= i_cmd_ctl.rd_en;
            r_v2 <= r_v1;
            if (we) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd_ctl.capture) begin
                r_idx        <= '0;
                r_best_found <= 1'b0;
            end else begin
                if (i_cmd_ctl.rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_v2 && r_hit) begin
                    r_best_found <= 1'b1;
                end
            end
            if (i_cmd_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_lookup = (r_cmd == CMD_LOOKUP);
    assign o_sts.scan_more = (r_idx < r_count);
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_location = r_found_location;

endmodule

[rtl/core/ordered_prefix_location_lookup_unit.sv]
`timescale 1ns / 1ps
// insert: the beat passes the start, write and output states before the result is registered
// lookup: one table read per cycle up to the entry count, then the compare pipe drains
// throughput: one item at a time, next beat taken once the result sits in the output register
// reset: synchronous active low, clears entry count, controller and output valid
// table contents are not cleared, only slots below the entry count are ever read

module ordered_prefix_location_lookup_unit
    import oplook_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_map_id,
    input  logic [31:0] i_user_id,
    input  logic [31:0] i_ip_addr,
    input  logic [5:0]  i_prefix_len,
    input  logic [31:0] i_location,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_location
);

    // command and status between sequencer and datapath
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: takes a beat, then either writes one slot or walks the table
    oplook_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: entry table, scan pointer, two-stage compare and best-rank tracking
    // the best match keeps the lowest probe rank, earlier slots win on equal rank
    oplook_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_ctl        (dp_cmd),
        .o_sts            (dp_sts),
        .i_cmd            (i_cmd),
        .i_map_id         (i_map_id),
        .i_user_id        (i_user_id),
        .i_ip_addr        (i_ip_addr),
        .i_prefix_len     (i_prefix_len),
        .i_location       (i_location),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_location (o_found_location)
    );

endmodule

[sim/tb_ordered_prefix_location_lookup_unit.sv]
`timescale 1ns / 1ps

module tb_ordered_prefix_location_lookup_unit;
    import oplook_pkg::*;

    // table depth of the block under test
    localparam int SLOTS         = 256;
    // random beats after the directed opening
    localparam int RANDOM_ITEMS  = 930;
    // cycles with no beat on either side before the run is declared hung;
    // worst case is a full-table lookup behind the receiver hold plus a
    // long random stall, so this is ample
    localparam int IDLE_LIMIT    = 4000;
    // receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES   = 300;
    // beat count at which the hold-off starts
    localparam int HOLD_AT_BEAT  = 40;

    // one pending input beat; wait_clear makes the sender idle until every
    // expected result has come back before offering it
    typedef struct {
        logic        cmd;
        logic [31:0] map_id;
        logic [31:0] user_id;
        logic [31:0] ip_addr;
        logic [5:0]  prefix_len;
        logic [31:0] location;
        bit          wait_clear;
    } lookup_req_t;

    // key of an entry that the table will hold, kept for aiming lookups
    typedef struct {
        logic [31:0] map_id;
        logic [31:0] user_id;
        logic [31:0] ip_addr;
        logic [5:0]  prefix_len;
    } stored_key_t;

    // what the block is expected to answer for one beat
    typedef struct {
        logic [1:0]  status;
        logic [31:0] location;
    } answer_t;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    // block ports, inputs all known from time zero
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic        i_cmd        = CMD_INSERT;
    logic [31:0] i_map_id     = '0;
    logic [31:0] i_user_id    = '0;
    logic [31:0] i_ip_addr    = '0;
    logic [5:0]  i_prefix_len = '0;
    logic [31:0] i_location   = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_found_location;

    ordered_prefix_location_lookup_unit #(
        .TABLE_ENTRIES(SLOTS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_map_id         (i_map_id),
        .i_user_id        (i_user_id),
        .i_ip_addr        (i_ip_addr),
        .i_prefix_len     (i_prefix_len),
        .i_location       (i_location),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_location (o_found_location)
    );

    // handshake beats as seen at the rising edge
    wire in_beat  = i_in_valid && !o_in_stall;
    wire out_beat = o_out_valid && !i_out_stall;

    // shadow table that mirrors what the block should hold
    logic [31:0] slot_map   [SLOTS];
    logic [31:0] slot_user  [SLOTS];
    logic [31:0] slot_addr  [SLOTS];
    logic [5:0]  slot_len   [SLOTS];
    logic [31:0] slot_value [SLOTS];
    int          slots_used = 0;

    // stimulus side
    lookup_req_t cmd_backlog [$];
    stored_key_t stored_keys [$];
    int          keys_generated = 0;
    lookup_req_t cur_req;
    bit          in_busy  = 1'b0;
    bit          in_fire  = 1'b0;
    int          tx_gap   = 0;
    bit          tx_quiet = 1'b0;

    // result side
    answer_t     answers_due [$];
    int          rx_stall_left = 0;
    int          hold_left     = 0;
    bit          hold_req      = 1'b0;
    bit          rx_quiet      = 1'b0;

    int          beats_in     = 0;
    int          results_seen = 0;
    int          idle_cycles  = 0;
    int          errors       = 0;

    // top len bits set; zero gives no bits, 32 and above give all of them
    function automatic logic [31:0] top_bits(input logic [5:0] len);
        if (len == 6'd0) begin
            return 32'h0;
        end
        if (len >= 6'd32) begin
            return 32'hFFFF_FFFF;
        end
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    // prefix length tried at position p of a lookup
    function automatic logic [5:0] probe_length(input int p);
        case (p)
            0:  return 6'd24;
            1:  return 6'd28;
            2:  return 6'd29;
            3:  return 6'd27;
            4:  return 6'd32;
            5:  return 6'd23;
            6:  return 6'd26;
            7:  return 6'd30;
            8:  return 6'd25;
            9:  return 6'd22;
            10: return 6'd19;
            11: return 6'd21;
            12: return 6'd20;
            13: return 6'd16;
            14: return 6'd18;
            15: return 6'd31;
            16: return 6'd17;
            // then the short prefixes, 15 down to 1
            default: return 6'(32 - p);
        endcase
    endfunction

    // applies one accepted beat to the shadow table and returns the answer
    function automatic answer_t table_answer(input logic cmd, input logic [31:0] mid,
                                             input logic [31:0] uid,
                                             input logic [31:0] addr,
                                             input logic [5:0] plen,
                                             input logic [31:0] loc);
        answer_t     ans;
        logic [31:0] key;
        logic [5:0]  len;
        int          p;
        int          k;
        ans.status   = ST_NOT_FOUND;
        ans.location = '0;
        if (cmd == CMD_INSERT) begin
            if (slots_used >= SLOTS) begin
                ans.status = ST_FULL;
                return ans;
            end
            // stored as given, host bits and all
            slot_map[slots_used]   = mid;
            slot_user[slots_used]  = uid;
            slot_addr[slots_used]  = addr;
            slot_len[slots_used]   = plen;
            slot_value[slots_used] = loc;
            slots_used++;
            ans.status = ST_OK;
            return ans;
        end
        // probe order decides first, insertion order breaks ties
        for (p = 0; p < 32; p++) begin
            len = probe_length(p);
            key = addr & top_bits(len);
            for (k = 0; k < slots_used; k++) begin
                if (slot_map[k] == mid && slot_user[k] == uid &&
                    slot_addr[k] == key && slot_len[k] == len) begin
                    ans.status   = ST_OK;
                    ans.location = slot_value[k];
                    return ans;
                end
            end
        end
        return ans;
    endfunction

    // mostly valid lengths, now and then zero or past 32
    function automatic logic [5:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 6'd0;
        end
        if (r < 8) begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(1, 32));
    endfunction

    // sender gap after a beat: mostly none or short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // queues a beat and remembers the key of any insert that will fit
    task automatic queue_item(input logic cmd, input logic [31:0] mid,
                              input logic [31:0] uid, input logic [31:0] addr,
                              input logic [5:0] plen, input logic [31:0] loc,
                              input bit wait_clear);
        lookup_req_t req;
        stored_key_t sk;
        req.cmd        = cmd;
        req.map_id     = mid;
        req.user_id    = uid;
        req.ip_addr    = addr;
        req.prefix_len = plen;
        req.location   = loc;
        req.wait_clear = wait_clear;
        cmd_backlog.push_back(req);
        if (cmd == CMD_INSERT) begin
            if (keys_generated < SLOTS) begin
                sk.map_id     = mid;
                sk.user_id    = uid;
                sk.ip_addr    = addr;
                sk.prefix_len = plen;
                stored_keys.push_back(sk);
            end
            keys_generated++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // sender: one beat held until accepted, then a random gap
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                in_fire = 1'b0;
                in_busy = 1'b0;
                tx_gap  = pick_gap(tx_quiet);
            end
            if (!in_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (cmd_backlog.size() > 0 &&
                             !(cmd_backlog[0].wait_clear && answers_due.size() > 0)) begin
                    cur_req = cmd_backlog.pop_front();
                    in_busy = 1'b1;
                end
            end
            i_in_valid <= in_busy;
            if (in_busy) begin
                i_cmd        <= cur_req.cmd;
                i_map_id     <= cur_req.map_id;
                i_user_id    <= cur_req.user_id;
                i_ip_addr    <= cur_req.ip_addr;
                i_prefix_len <= cur_req.prefix_len;
                i_location   <= cur_req.location;
            end
        end
    end

    // accepted input beat: predict its answer right away, the block works
    // on one item at a time so answers come back in beat order
    always @(posedge i_clk) begin
        if (i_rst_n && in_beat) begin
            answers_due.push_back(table_answer(i_cmd, i_map_id, i_user_id, i_ip_addr,
                                               i_prefix_len, i_location));
            in_fire = 1'b1;
            beats_in++;
            if (beats_in == HOLD_AT_BEAT) begin
                hold_req = 1'b1;
            end
            if (beats_in % 97 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // receiver stall: one long hold, otherwise random short and long stalls
    always @(negedge i_clk) begin
        bit stall;
        int r;
        stall = 1'b0;
        if (i_rst_n) begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall = 1'b1;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                stall = 1'b1;
            end else if (!rx_quiet) begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    rx_stall_left = $urandom_range(0, 3);
                    stall = 1'b1;
                end else if (r < 23) begin
                    rx_stall_left = $urandom_range(10, 40);
                    stall = 1'b1;
                end
            end
        end
        i_out_stall <= stall;
    end

    // result check against the oldest expected answer
    always @(posedge i_clk) begin
        answer_t want;
        if (i_rst_n && out_beat) begin
            results_seen++;
            if (results_seen % 89 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result beat", 32'(o_status), o_found_location);
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                end
                if (o_found_location !== want.location) begin
                    report_mismatch("found_location", o_found_location, want.location);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_beat || out_beat) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] map_pool  [4];
        logic [31:0] user_pool [4];
        stored_key_t e;
        logic [31:0] a;
        logic [5:0]  len;
        int          i;
        int          r;
        int          k;
        bit          wc;

        map_pool  = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
        user_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};

        // directed opening
        // lookup on an empty table misses
        queue_item(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 6'd0, 32'h0, 1'b0);
        // length zero is stored but can never match
        queue_item(CMD_INSERT, 32'h0, 32'h0, 32'h0, 6'd0, 32'hFFFF_FFFF, 1'b0);
        queue_item(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 6'd0, 32'h0, 1'b0);
        // all-ones key, full-length prefix
        queue_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32,
                   32'h1234_5678, 1'b0);
        queue_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63,
                   32'hFFFF_FFFF, 1'b0);
        // nested prefixes under one map and user
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A00_0000, 6'd8,  32'h08, 1'b0);
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_0000, 6'd16, 32'h16, 1'b0);
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_0200, 6'd24, 32'h24, 1'b0);
        // same key again, the earlier insert keeps winning
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_0200, 6'd24, 32'h99, 1'b0);
        // host bits below the prefix, never matches
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_02FF, 6'd28, 32'hBAD, 1'b0);
        // longer than 24 but probed later
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_0280, 6'd25, 32'h25, 1'b0);
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_02F0, 6'd28, 32'h28, 1'b0);
        // lengths past 32 are stored but never probed
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_02F5, 6'd33, 32'h33, 1'b0);
        queue_item(CMD_INSERT, 32'h1, 32'h2, 32'h0A01_02F5, 6'd63, 32'h63, 1'b0);
        queue_item(CMD_INSERT, 32'h1, 32'h3, 32'h8000_0000, 6'd1,  32'h01, 1'b0);
        queue_item(CMD_LOOKUP, 32'h1, 32'h2, 32'h0A01_02F5, 6'd0,  32'h0, 1'b0);
        queue_item(CMD_LOOKUP, 32'h1, 32'h2, 32'h0A01_03FF, 6'd0,  32'h0, 1'b0);
        queue_item(CMD_LOOKUP, 32'h1, 32'h2, 32'h0A7F_0000, 6'd0,  32'h0, 1'b0);
        queue_item(CMD_LOOKUP, 32'h1, 32'h2, 32'h0B00_0000, 6'd0,  32'h0, 1'b0);
        queue_item(CMD_LOOKUP, 32'h1, 32'h3, 32'hFFFF_FFFF, 6'd0,  32'h0, 1'b0);
        queue_item(CMD_LOOKUP, 32'h1, 32'h3, 32'h7FFF_FFFF, 6'd0,  32'h0, 1'b0);
        // map mismatch misses
        queue_item(CMD_LOOKUP, 32'h2, 32'h2, 32'h0A01_02FF, 6'd0,  32'h0, 1'b0);

        // random part: the table fills up along the way and later inserts
        // hit the full status; lookups mostly aim at stored prefixes
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            r  = $urandom_range(0, 99);
            wc = (i % 150 == 0);
            if (r < 35) begin
                k = $urandom_range(0, 99);
                if (stored_keys.size() > 0 && k < 55) begin
                    e = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                    if (k < 15) begin
                        // duplicate key, tie goes to the older entry
                        queue_item(CMD_INSERT, e.map_id, e.user_id, e.ip_addr, e.prefix_len,
                                   $urandom, wc);
                    end else begin
                        // new length sharing the prefix of a stored entry
                        len = rand_len();
                        a = (e.ip_addr | ($urandom & ~top_bits(e.prefix_len))) & top_bits(len);
                        if ($urandom_range(0, 9) == 0) begin
                            a = a | ($urandom & ~top_bits(len));
                        end
                        queue_item(CMD_INSERT, e.map_id, e.user_id, a, len, $urandom, wc);
                    end
                end else begin
                    len = rand_len();
                    a   = $urandom;
                    if ($urandom_range(0, 9) < 8) begin
                        a = a & top_bits(len);
                    end
                    queue_item(CMD_INSERT, map_pool[$urandom_range(0, 3)],
                               user_pool[$urandom_range(0, 3)], a, len, $urandom, wc);
                end
            end else if (r < 80 && stored_keys.size() > 0) begin
                // address inside a stored prefix, random host bits
                e = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                a = (e.ip_addr & top_bits(e.prefix_len)) | ($urandom & ~top_bits(e.prefix_len));
                queue_item(CMD_LOOKUP, e.map_id, e.user_id, a,
                           6'($urandom_range(0, 63)), $urandom, wc);
            end else begin
                // noise lookup, mostly misses
                queue_item(CMD_LOOKUP,
                           ($urandom_range(0, 1) == 1) ? map_pool[$urandom_range(0, 3)] : $urandom,
                           ($urandom_range(0, 1) == 1) ? user_pool[$urandom_range(0, 3)] : $urandom,
                           $urandom, 6'($urandom_range(0, 63)), $urandom, wc);
            end
        end

        // single reset at the start
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the last beat to go in, then for every answer
        while (cmd_backlog.size() > 0 || in_busy) begin
            @(posedge i_clk);
        end
        while (answers_due.size() > 0) begin
            @(posedge i_clk);
        end
        // catch any stray result beat
        repeat (40) @(posedge i_clk);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
